/* hdl/itda_pkg.sv */
// Shared constants and types for the decimal ASCII formatter.
package itda_pkg;

   localparam int VALUE_W    = 32;
   localparam int OP_W       = 2;
   localparam int CHAR_W     = 8;
   localparam int DIGIT_W    = 4;
   localparam int NUM_DIGITS = 10;
   localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
   localparam int BIT_CNT_W  = $clog2(VALUE_W + 1);
   localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

   localparam logic [CHAR_W-1:0]  CH_MINUS = 8'd45;
   localparam logic [CHAR_W-1:0]  CH_ZERO  = 8'd48;
   localparam logic [VALUE_W-1:0] RADIX    = 32'd10;

   // Format selector codes. Bit 1 clear means the value is two's complement.
   localparam logic [OP_W-1:0] OP_SIGNED    = 2'd0;
   localparam logic [OP_W-1:0] OP_LEAD_ZERO = 2'd1;
   localparam logic [OP_W-1:0] OP_UNSIGNED  = 2'd2;

   // Status of the binary to BCD converter, seen by the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } itda_conv_stat_type;

endpackage

/* hdl/itda_channels.sv */
// Valid/ready channel interfaces for the request and response words.
interface itda_req_if import itda_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] value;
   logic [OP_W-1:0]    operation;

   modport source (output valid, output value, output operation, input ready);
   modport sink   (input valid, input value, input operation, output ready);
endinterface

interface itda_rsp_if import itda_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] ascii_char;
   logic              last;

   modport source (output valid, output ascii_char, output last, input ready);
   modport sink   (input valid, input ascii_char, input last, output ready);
endinterface

/* hdl/itda_dabble.sv */
// Iterative shift-and-add-3 binary to BCD converter, one input bit per cycle.
module itda_dabble import itda_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [VALUE_W-1:0] bin,
   output itda_conv_stat_type stat,
   output logic [BCD_W-1:0]   bcd
);

   logic [VALUE_W-1:0]   shift_ff, shift_in;
   logic [BCD_W-1:0]     bcd_ff, bcd_in;
   logic [BIT_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [BCD_W-1:0]     adj;

   // Each digit of five or more gets three added before the shift.
   always_comb begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
         if (bcd_ff[d*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
            adj[d*DIGIT_W +: DIGIT_W] = bcd_ff[d*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
         end else begin
            adj[d*DIGIT_W +: DIGIT_W] = bcd_ff[d*DIGIT_W +: DIGIT_W];
         end
      end
   end

   always_comb begin
      shift_in = shift_ff;
      bcd_in   = bcd_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      if (start) begin
         shift_in = bin;
         bcd_in   = '0;
         cnt_in   = BIT_CNT_W'(VALUE_W);
      end else if (cnt_ff != '0) begin
         bcd_in   = {adj[BCD_W-2:0], shift_ff[VALUE_W-1]};
         shift_in = {shift_ff[VALUE_W-2:0], 1'b0};
         cnt_in   = cnt_ff - BIT_CNT_W'(1);
         done_in  = (cnt_ff == BIT_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      shift_ff <= shift_in;
      bcd_ff   <= bcd_in;
   end

   assign stat.busy = (cnt_ff != '0);
   assign stat.done = done_ff;
   assign bcd       = bcd_ff;

endmodule

/* hdl/integer_to_decimal_ascii.sv */
// Top level of the decimal ASCII formatter: sequencer and character output stage.
//
// Each request word carries a 32-bit value and a format selector; the block answers
// with the value's decimal text, one ASCII character per response word, most
// significant digit first, with last set on the final character. In signed mode a
// negative value gets a leading '-' and then the digits of its magnitude (the most
// negative value prints as -2147483648); the leading-zero mode also puts a '0' before
// a single-digit magnitude; unsigned mode, and the undefined selector three, read all
// 32 bits as magnitude. The block takes one request at a time and drops ready until
// the final character of that number sits in the output register. From acceptance to
// the next acceptance a number passes through the shift-and-add-3 converter (one input
// bit per cycle), the pickup of its result, the dropping of suppressed leading zero
// digits, the output of its characters as the response side takes them, and an idle
// state for the handshake. The output register lets the last character wait for the
// consumer while the next word is taken.

module integer_to_decimal_ascii import itda_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   itda_req_if.sink   req_if,
   itda_rsp_if.source rsp_if
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CONV = 4'b0010,
      ST_TRIM = 4'b0100,
      ST_EMIT = 4'b1000
   } itda_state_type;

   itda_state_type       state_ff, state_in;
   logic                 minus_ff, minus_in;
   logic                 zero_ff, zero_in;
   logic [BCD_W-1:0]     dig_ff, dig_in;
   logic [DIG_CNT_W-1:0] dcnt_ff, dcnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]    rsp_char_ff, rsp_char_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 accept;
   logic                 neg;
   logic [VALUE_W-1:0]   mag;
   logic                 slot_free;
   itda_conv_stat_type   conv_stat;
   logic [BCD_W-1:0]     conv_bcd;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign accept       = req_if.valid && req_if.ready;

   // Only bit 1 of the selector decides signedness. The magnitude of a negative
   // number is formed as an unsigned 32-bit value, so the most negative one is fine.
   assign neg = !req_if.operation[1] && req_if.value[VALUE_W-1];
   assign mag = neg ? (~req_if.value + VALUE_W'(1)) : req_if.value;

   itda_dabble u_dabble (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .bin   (mag),
      .stat  (conv_stat),
      .bcd   (conv_bcd)
   );

   // The output register can take a new character when it is empty or being drained.
   assign slot_free = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      state_in     = state_ff;
      minus_in     = minus_ff;
      zero_in      = zero_ff;
      dig_in       = dig_ff;
      dcnt_in      = dcnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               minus_in = neg;
               zero_in  = (req_if.operation == OP_LEAD_ZERO) && (mag < RADIX);
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            if (conv_stat.done) begin
               dig_in   = conv_bcd;
               dcnt_in  = DIG_CNT_W'(NUM_DIGITS);
               state_in = ST_TRIM;
            end
         end
         ST_TRIM: begin
            // Drop leading zero digits one per cycle, always keeping at least one.
            if ((dig_ff[BCD_W-1 -: DIGIT_W] == '0) && (dcnt_ff > DIG_CNT_W'(1))) begin
               dig_in  = {dig_ff[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
               dcnt_in = dcnt_ff - DIG_CNT_W'(1);
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (minus_ff) begin
                  rsp_char_in = CH_MINUS;
                  rsp_last_in = 1'b0;
                  minus_in    = 1'b0;
               end else if (zero_ff) begin
                  rsp_char_in = CH_ZERO;
                  rsp_last_in = 1'b0;
                  zero_in     = 1'b0;
               end else begin
                  rsp_char_in = CH_ZERO + CHAR_W'(dig_ff[BCD_W-1 -: DIGIT_W]);
                  rsp_last_in = (dcnt_ff == DIG_CNT_W'(1));
                  dig_in      = {dig_ff[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                  dcnt_in     = dcnt_ff - DIG_CNT_W'(1);
                  if (dcnt_ff == DIG_CNT_W'(1)) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      minus_ff    <= minus_in;
      zero_ff     <= zero_in;
      dig_ff      <= dig_in;
      dcnt_ff     <= dcnt_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.ascii_char = rsp_char_ff;
   assign rsp_if.last       = rsp_last_ff;

   // The converter finishes only while the sequencer is waiting for it.
   a_done_in_conv: assert property (@(posedge clock) disable iff (reset)
      conv_stat.done |-> (state_ff == ST_CONV))
      else $error("converter finished outside the conversion state");

   // The converter is idle whenever a new word can be taken.
   a_conv_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !conv_stat.busy)
      else $error("converter busy while the block is idle");

   // While characters are produced there is always at least one digit left.
   a_digits_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (dcnt_ff != '0))
      else $error("digit count ran out during emission");

   // Every character put out is a minus sign or a decimal digit.
   a_char_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_char_ff == CH_MINUS) ||
                        ((rsp_char_ff >= CH_ZERO) && (rsp_char_ff <= CH_ZERO + CHAR_W'(9)))))
      else $error("character outside the decimal set");

endmodule

/* tb/tb.sv */
// Self-checking testbench for the decimal ASCII formatter, with an internal text predictor.
module tb import itda_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   // One request word as the driver holds it. When drain_first is set, the driver
   // waits until every character already predicted has come out before it shows
   // this word. This makes the block start from a fully drained state.
   typedef struct {
      logic [VALUE_W-1:0] value;
      logic [OP_W-1:0]    operation;
      bit                 drain_first;
   } number_word_type;

   // One response word: a character and its end-of-text flag.
   typedef struct {
      logic [CHAR_W-1:0] ascii_char;
      logic              last;
   } text_char_type;

   logic clock;
   logic reset;

   itda_req_if req_if();
   itda_rsp_if rsp_if();

   integer_to_decimal_ascii uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   number_word_type pending_numbers[$];   // words not yet shown to the block
   text_char_type   expected_text[$];     // characters predicted but not yet seen
   int              mismatch_count = 0;
   logic            req_taken;            // a request word was accepted at the last rising edge

   // Sender burst control and receiver stall pattern.
   int burst_left  = 0;
   int gap_left    = 0;
   int stall_mode  = 0;
   int stall_timer = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // The predictor works out the decimal text of one number and appends it to the
   // characters expected from the block. Bit 1 of the selector decides signedness,
   // so selector three reads the value as unsigned. The magnitude is computed at
   // 32 bits, so the most negative value keeps its full magnitude 2147483648.
   function automatic void predict_text(input logic [VALUE_W-1:0] value,
                                        input logic [OP_W-1:0]    operation);
      logic [VALUE_W-1:0] magnitude;
      logic [DIGIT_W-1:0] digits [NUM_DIGITS];
      text_char_type      text[$];
      int                 n;
      bit                 negative;
      bit                 pad_zero;
      negative  = (operation[1] == 1'b0) && value[VALUE_W-1];
      pad_zero  = (operation == OP_LEAD_ZERO);
      magnitude = negative ? (~value + 32'd1) : value;
      if (negative) begin
         text.push_back(text_char_type'{CH_MINUS, 1'b0});
      end
      // The leading-zero format pads a single-digit magnitude to two digits.
      if (pad_zero && magnitude < RADIX) begin
         text.push_back(text_char_type'{CH_ZERO, 1'b0});
      end
      // Peel off digits least significant first; zero still yields one digit.
      n = 0;
      do begin
         digits[n] = DIGIT_W'(magnitude % RADIX);
         magnitude = magnitude / RADIX;
         n++;
      end while (magnitude != 0 && n < NUM_DIGITS);
      while (n > 0) begin
         n--;
         text.push_back(text_char_type'{CH_ZERO + CHAR_W'(digits[n]), 1'b0});
      end
      text[text.size() - 1].last = 1'b1;
      foreach (text[i]) expected_text.push_back(text[i]);
   endfunction

   // Driver. Inputs change only on the falling edge. A word that is shown is held
   // until it is accepted. Between words the sender runs in bursts of random length.
   // Random gaps separate the bursts, so new words arrive at every phase of the
   // block's conversion. Some bursts are followed by no gap at all.
   always @(negedge clock) begin
      if (!reset) begin
         if (req_if.valid && !req_taken) begin
            // The shown word is still waiting for ready; keep it stable.
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_if.valid <= 1'b0;
         end else if (pending_numbers.size() == 0) begin
            req_if.valid <= 1'b0;
         end else if (pending_numbers[0].drain_first && expected_text.size() != 0) begin
            // Hold off until the block has delivered all text of earlier numbers.
            req_if.valid <= 1'b0;
         end else begin
            req_if.valid     <= 1'b1;
            req_if.value     <= pending_numbers[0].value;
            req_if.operation <= pending_numbers[0].operation;
            void'(pending_numbers.pop_front());
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 12);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end
   end

   // Receiver. Ready follows a pattern that changes at random intervals. The
   // modes are: always ready, mostly ready, mostly stalled, and a periodic one-in-five
   // stall. The stalls make the output register hold the final character while the
   // next word is taken.
   always @(negedge clock) begin
      if (!reset) begin
         if (stall_timer == 0) begin
            stall_mode  = $urandom_range(0, 3);
            stall_timer = $urandom_range(50, 400);
         end else begin
            stall_timer = stall_timer - 1;
         end
         case (stall_mode)
            0: begin
               rsp_if.ready <= 1'b1;
            end
            1: begin
               rsp_if.ready <= ($urandom_range(0, 3) != 0);
            end
            2: begin
               rsp_if.ready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
               rsp_if.ready <= (stall_timer % 5 != 0);
            end
         endcase
      end
   end

   // Monitor. Both channels are sampled on the rising edge. Each accepted request
   // word is predicted at once. Each accepted response word is checked against the
   // oldest predicted character.
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_if.valid && req_if.ready;
         if (req_if.valid && req_if.ready) begin
            predict_text(req_if.value, req_if.operation);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_text.size() == 0) begin
               $error("unexpected response word: ascii_char %0d, last %0b",
                      rsp_if.ascii_char, rsp_if.last);
               mismatch_count++;
            end else begin
               if (rsp_if.ascii_char !== expected_text[0].ascii_char) begin
                  $error("ascii_char mismatch: expected %0d, actual %0d",
                         expected_text[0].ascii_char, rsp_if.ascii_char);
                  mismatch_count++;
               end
               if (rsp_if.last !== expected_text[0].last) begin
                  $error("last mismatch: expected %0b, actual %0b",
                         expected_text[0].last, rsp_if.last);
                  mismatch_count++;
               end
               void'(expected_text.pop_front());
            end
         end
      end
   end

   // Stimulus and end of test.
   initial begin
      number_word_type w;
      logic [VALUE_W-1:0] power;
      int kind;

      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.value     = '0;
      req_if.operation = OP_SIGNED;
      rsp_if.ready     = 1'b0;

      // Directed words cover zero in every format and the padding boundary at
      // nine and ten. They also cover the most negative and the most positive
      // signed values, all ones in every format, and the widest unsigned numbers.
      w.drain_first = 1'b0;
      for (int op = 0; op < 4; op++) begin
         w.value = 32'd0;          w.operation = OP_W'(op); pending_numbers.push_back(w);
         w.value = 32'hFFFF_FFFF;  w.operation = OP_W'(op); pending_numbers.push_back(w);
         w.value = 32'h8000_0000;  w.operation = OP_W'(op); pending_numbers.push_back(w);
      end
      w.value = 32'd5;            w.operation = OP_LEAD_ZERO; pending_numbers.push_back(w);
      w.value = -32'sd5;          w.operation = OP_LEAD_ZERO; pending_numbers.push_back(w);
      w.value = -32'sd5;          w.operation = OP_SIGNED;    pending_numbers.push_back(w);
      w.value = 32'd9;            w.operation = OP_LEAD_ZERO; pending_numbers.push_back(w);
      w.value = 32'd10;           w.operation = OP_LEAD_ZERO; pending_numbers.push_back(w);
      w.value = -32'sd10;         w.operation = OP_LEAD_ZERO; pending_numbers.push_back(w);
      w.value = 32'h7FFF_FFFF;    w.operation = OP_SIGNED;    pending_numbers.push_back(w);
      w.value = 32'd1000000000;   w.operation = OP_UNSIGNED;  pending_numbers.push_back(w);
      w.value = 32'd999999999;    w.operation = OP_SIGNED;    pending_numbers.push_back(w);
      w.value = 32'hAAAA_5555;    w.operation = OP_UNSIGNED;  pending_numbers.push_back(w);

      // Random words mix full-range values with short numbers near the padding
      // boundary. They also include powers of ten and their neighbors, where the
      // digit count changes, values close to the signed and unsigned extremes, and
      // values of random bit length. The selector is mostly one of the three
      // defined formats, with selector three now and then. Every fortieth word
      // first waits for the block to drain.
      for (int i = 0; i < 230; i++) begin
         kind = $urandom_range(0, 4);
         case (kind)
            0: begin
               w.value = $urandom;
            end
            1: begin
               w.value = $urandom_range(0, 12);
               if ($urandom_range(0, 1) == 1) w.value = -w.value;
            end
            2: begin
               power = 32'd1;
               repeat ($urandom_range(0, 9)) power = power * 32'd10;
               w.value = power + $urandom_range(0, 2) - 32'd1;
               if ($urandom_range(0, 2) == 0) w.value = -w.value;
            end
            3: begin
               case ($urandom_range(0, 2))
                  0:       w.value = 32'h8000_0000 + $urandom_range(0, 3);
                  1:       w.value = 32'h7FFF_FFFF - $urandom_range(0, 3);
                  default: w.value = 32'hFFFF_FFFF - $urandom_range(0, 3);
               endcase
            end
            default: begin
               w.value = $urandom >> $urandom_range(0, 31);
            end
         endcase
         w.operation   = ($urandom_range(0, 7) == 0) ? 2'd3 : OP_W'($urandom_range(0, 2));
         w.drain_first = (i % 40 == 39);
         pending_numbers.push_back(w);
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait until every word is accepted and all predicted text has arrived. Then
      // give the block time to show any stray word before the verdict.
      while (pending_numbers.size() != 0 || req_if.valid || expected_text.size() != 0) begin
         @(negedge clock);
      end
      repeat (100) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #1_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
